FILE: design/assert_macros.svh
// Assertion macros used by the decluttering top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset.
`define GLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define GLD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define GLD_ASSERT(lbl, prop, msg)
`define GLD_NEVER(lbl, expr, msg)

`endif

`endif

FILE: design/gld_pkg.sv
// Types, codes and sizing constants of the label decluttering block.
`timescale 1ns / 1ps

package gld_pkg;

    // Sizing
    localparam int MAX_ACCEPTED = 256;
    localparam int GROUP_COUNT  = 1024;
    localparam int COORD_BITS   = 16;

    localparam int BOX_ADDR_BITS = $clog2(MAX_ACCEPTED);
    localparam int COUNT_BITS    = $clog2(MAX_ACCEPTED + 1);
    localparam int GROUP_BITS    = $clog2(GROUP_COUNT);
    localparam int EPOCH_BITS    = 8;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    // Function codes
    localparam logic [1:0] FUNC_NEW_FRAME = 2'd0;
    localparam logic [1:0] FUNC_PLACE     = 2'd1;
    localparam logic [1:0] FUNC_QUERY     = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_SHOWN    = 2'd0;
    localparam logic [1:0] VERDICT_OCCLUDED = 2'd1;
    localparam logic [1:0] VERDICT_DROPPED  = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLED     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VISIBLE = 2'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] box_left;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic signed [15:0] box_top;
        logic [9:0]         group_id;
    } gld_item_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       group_culled;
    } gld_result_t;

    // One entry of the accepted box store
    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] bottom;
        logic signed [COORD_BITS-1:0] top;
        logic [GROUP_BITS-1:0]        group;
    } gld_box_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_CHK,
        ST_SCAN
    } gld_state_t;

endpackage

FILE: design/gld_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/greedy_label_declutter.sv
// Top level of the greedy label decluttering block: control, box store and culled-group map.
// Place: unless disabled or full, the culled-group map is checked, then the box scan reads
//   one stored box a cycle from the box RAM; the next start is taken in the done cycle.
// Query: reads the culled-group map. New frame: busy every 255th frame
//   while the culled-group map is wiped. The receiver cannot stall the done strobe.
// Reset: asynchronous, active low; clears control state, then wipes the culled-group
//   map with busy high. Config writes are taken throughout.
`timescale 1ns / 1ps

module greedy_label_declutter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  gld_pkg::gld_item_t                 item,
    output logic                               done,
    output gld_pkg::gld_result_t               result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gld_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gld_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import gld_pkg::*;

    `include "assert_macros.svh"

    gld_state_t              state_reg, state_next;
    logic                    enabled_reg;
    logic [8:0]              max_vis_reg;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic [EPOCH_BITS-1:0]   epoch_reg, epoch_next;
    logic [GROUP_BITS-1:0]   clr_idx_reg, clr_idx_next;
    logic                    done_reg, done_next;
    gld_item_t               item_reg, item_next;
    gld_result_t             result_reg, result_next;

    logic [COUNT_BITS-1:0]   limit;
    logic [GROUP_BITS-1:0]   item_group;

    // Culled-group map: one epoch tag per group
    logic                    map_we, map_re;
    logic [GROUP_BITS-1:0]   map_waddr, map_raddr;
    logic [EPOCH_BITS-1:0]   map_wdata, map_rdata;
    logic                    map_culled;

    // Accepted box store
    logic                    box_we, box_re;
    logic [BOX_ADDR_BITS-1:0] box_waddr, box_raddr;
    gld_box_t                box_wdata, box_rdata;
    logic                    box_hit;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign item_group = item_reg.group_id[GROUP_BITS-1:0];
    assign map_culled = (map_rdata == epoch_reg);

    // Effective limit: min(max_visible, MAX_ACCEPTED)
    always_comb
    begin
        if (32'(max_vis_reg) > 32'(MAX_ACCEPTED))
        begin
            limit = COUNT_BITS'(MAX_ACCEPTED);
        end
        else
        begin
            limit = COUNT_BITS'(max_vis_reg);
        end
    end

    // Overlap against the box just read, if it is of another group; shared edges count as overlap
    always_comb
    begin
        box_hit = (box_rdata.group != item_group) &&
                  !(box_wdata.left   > box_rdata.right  ||
                    box_wdata.right  < box_rdata.left   ||
                    box_wdata.bottom > box_rdata.top    ||
                    box_wdata.top    < box_rdata.bottom);
    end

    // Stored form of the held label
    always_comb
    begin
        box_wdata.left   = signed'(item_reg.box_left[COORD_BITS-1:0]);
        box_wdata.right  = signed'(item_reg.box_right[COORD_BITS-1:0]);
        box_wdata.bottom = signed'(item_reg.box_bottom[COORD_BITS-1:0]);
        box_wdata.top    = signed'(item_reg.box_top[COORD_BITS-1:0]);
        box_wdata.group  = item_group;
    end

    assign box_waddr = count_reg[BOX_ADDR_BITS-1:0];
    assign box_raddr = idx_reg[BOX_ADDR_BITS-1:0];

    // Next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        epoch_next   = epoch_reg;
        clr_idx_next = clr_idx_reg;
        done_next    = 1'b0;
        item_next    = item_reg;
        result_next  = result_reg;
        map_re       = 1'b0;
        map_raddr    = item.group_id[GROUP_BITS-1:0];
        map_we       = 1'b0;
        map_waddr    = item_group;
        map_wdata    = epoch_reg;
        box_re       = 1'b0;
        box_we       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Wipe one map entry a cycle
                map_we       = 1'b1;
                map_waddr    = clr_idx_reg;
                map_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == GROUP_BITS'(GROUP_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    result_next = '0;
                    unique case (item.func)
                        FUNC_NEW_FRAME:
                        begin
                            // Drop all boxes; retire the map by moving to a new epoch, wiping it when the epoch wraps
                            count_next = '0;
                            done_next  = 1'b1;
                            if (epoch_reg == '1)
                            begin
                                epoch_next   = EPOCH_BITS'(1);
                                clr_idx_next = '0;
                                state_next   = ST_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                        FUNC_PLACE:
                        begin
                            if (!enabled_reg)
                            begin
                                done_next = 1'b1;
                            end
                            else if (count_reg >= limit)
                            begin
                                result_next.verdict = VERDICT_DROPPED;
                                done_next           = 1'b1;
                            end
                            else
                            begin
                                map_re     = 1'b1;
                                state_next = ST_MAP_CHK;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            map_re     = 1'b1;
                            state_next = ST_MAP_CHK;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_MAP_CHK:
            begin
                if (item_reg.func == FUNC_QUERY)
                begin
                    result_next.group_culled = map_culled;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else if (map_culled)
                begin
                    result_next.verdict = VERDICT_OCCLUDED;
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read a cycle, compare the one that returned
                box_re    = (idx_reg < count_reg);
                pend_next = box_re;
                if (box_re)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg && box_hit)
                begin
                    map_we              = 1'b1;
                    result_next.verdict = VERDICT_OCCLUDED;
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
                else if (!box_re && !pend_reg)
                begin
                    box_we              = 1'b1;
                    count_next          = count_reg + 1'b1;
                    result_next.verdict = VERDICT_SHOWN;
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            epoch_reg   <= EPOCH_BITS'(1);
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            epoch_reg   <= epoch_next;
            clr_idx_reg <= clr_idx_next;
            done_reg    <= done_next;
        end
    end

    // Configuration transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            max_vis_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ENABLED)
            begin
                enabled_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_MAX_VISIBLE)
            begin
                max_vis_reg <= cfg_data[8:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    gld_ram #(
        .WIDTH (EPOCH_BITS),
        .DEPTH (GROUP_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    gld_ram #(
        .WIDTH ($bits(gld_box_t)),
        .DEPTH (MAX_ACCEPTED)
    ) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (box_waddr),
        .wdata (box_wdata),
        .re    (box_re),
        .raddr (box_raddr),
        .rdata (box_rdata)
    );

    `GLD_ASSERT(a_count_bound, count_reg <= COUNT_BITS'(MAX_ACCEPTED), "box count over capacity")
    `GLD_ASSERT(a_scan_index, (state_reg == ST_SCAN) |-> (idx_reg <= count_reg), "scan past fill")
    `GLD_NEVER(a_box_write_limit, box_we && (count_reg >= limit), "box stored over the limit")
    `GLD_ASSERT(a_map_chk_read, (state_reg == ST_MAP_CHK) |-> $past(map_re), "map check unread")
    `GLD_NEVER(a_epoch_zero, epoch_reg == '0, "epoch tag of wiped entries in use")

endmodule
